// ===== hdl/cle_pkg.sv =====
// Shared types and constants for the console line editor.
`timescale 1ns / 1ps
package cle_pkg;

    // Command kinds produced by the front classifier
    localparam logic [2:0] CMD_STORE = 3'd0;
    localparam logic [2:0] CMD_ERASE = 3'd1;
    localparam logic [2:0] CMD_KILL  = 3'd2;
    localparam logic [2:0] CMD_DROP  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Key codes
    localparam logic [7:0] KEY_NUL    = 8'h00;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_TAB    = 8'h09;
    localparam logic [7:0] KEY_LF     = 8'h0a;
    localparam logic [7:0] KEY_CR     = 8'h0d;
    localparam logic [7:0] KEY_DEL    = 8'h7f;
    localparam logic [7:0] KEY_AT     = 8'h40;
    localparam logic [7:0] KEY_CTRL_D = 8'h44 - KEY_AT;
    localparam logic [7:0] KEY_CTRL_P = 8'h50 - KEY_AT;
    localparam logic [7:0] KEY_CTRL_U = 8'h55 - KEY_AT;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] key;      // CR already turned into LF
        logic       started;
    } cmd_t;

    typedef struct packed {
        logic       read_empty;
        logic       read_eof;
        logic       read_line_end;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       line_committed;
        logic [9:0] erase_count;
        logic [7:0] echo_byte;
        logic       echo_valid;
    } res_t;

endpackage

// ===== hdl/cle_front.sv =====
// Front stage: accepts input words and classifies them into commands.
`timescale 1ns / 1ps
module cle_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_operation,
    input  logic [7:0]    s_key,
    input  logic          s_started,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output cle_pkg::cmd_t cmd
);
    import cle_pkg::*;

    logic cmd_valid_reg, cmd_valid_next;
    cmd_t cmd_reg, cmd_next;

    assign s_ready   = !cmd_valid_reg || cmd_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        cmd_next         = cmd_reg;
        cmd_valid_next   = cmd_valid_reg && !cmd_ready;
        if (s_valid && s_ready) begin
            cmd_valid_next   = 1'b1;
            cmd_next.key     = (s_key == KEY_CR) ? KEY_LF : s_key;
            cmd_next.started = s_started;
            if (s_operation) begin
                cmd_next.kind = CMD_READ;
            end else if (s_key == KEY_CTRL_U) begin
                cmd_next.kind = CMD_KILL;
            end else if (s_key == KEY_BS || s_key == KEY_DEL) begin
                cmd_next.kind = CMD_ERASE;
            end else if (s_key == KEY_NUL || s_key == KEY_TAB || s_key == KEY_CTRL_P) begin
                cmd_next.kind = CMD_DROP;
            end else begin
                cmd_next.kind = CMD_STORE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

// ===== hdl/cle_queue.sv =====
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
module cle_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  cle_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output cle_pkg::cmd_t out_cmd
);
    import cle_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== hdl/cle_back.sv =====
// Back end: ring buffer, read/commit/edit indices and the result register.
`timescale 1ns / 1ps
module cle_back #(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  cle_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output cle_pkg::res_t res
);
    import cle_pkg::*;

    localparam int IW = $clog2(2 * BUFFER_DEPTH);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [IW:0] MOD   = (IW + 1)'(2 * BUFFER_DEPTH);
    localparam logic [IW:0] DEPTH = (IW + 1)'(BUFFER_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
        logic [IW:0] s;
        s = {1'b0, x} + 1'b1;
        return (s == MOD) ? '0 : s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x);
        logic [IW:0] s;
        s = (x == '0) ? (MOD - 1'b1) : ({1'b0, x} - 1'b1);
        return s[IW-1:0];
    endfunction

    function automatic logic [IW:0] idx_dist(input logic [IW-1:0] a, input logic [IW-1:0] b);
        return (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + MOD - {1'b0, b});
    endfunction

    function automatic logic [AW-1:0] slot(input logic [IW-1:0] x);
        logic [IW:0] s;
        s = ({1'b0, x} >= DEPTH) ? ({1'b0, x} - DEPTH) : {1'b0, x};
        return s[AW-1:0];
    endfunction

    logic [7:0]    mem [BUFFER_DEPTH];
    logic [7:0]    rd_data_reg;

    logic          state_reg, state_next;
    logic [IW-1:0] read_idx_reg, read_idx_next;
    logic [IW-1:0] commit_idx_reg, commit_idx_next;
    logic [IW-1:0] edit_idx_reg, edit_idx_next;
    logic          started_reg, started_next;
    logic          res_valid_reg, res_valid_next;
    res_t          res_reg, res_next;

    logic          wr_en;
    logic [IW-1:0] edit_inc;
    logic [IW:0]   kill_count;
    logic [IW+9:0] erase_wide;

    assign cmd_ready = (state_reg == ST_IDLE) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign edit_inc   = idx_inc(edit_idx_reg);
    assign kill_count = idx_dist(edit_idx_reg, commit_idx_reg);
    assign erase_wide = {9'd0, kill_count};

    always_comb begin
        state_next      = state_reg;
        read_idx_next   = read_idx_reg;
        commit_idx_next = commit_idx_reg;
        edit_idx_next   = edit_idx_reg;
        started_next    = started_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_next        = res_reg;
        wr_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    res_next = '0;
                    if (cmd.kind == CMD_READ && read_idx_reg != commit_idx_reg) begin
                        // buffer read issued this cycle, data used in ST_READ next cycle
                        state_next   = ST_READ;
                        started_next = cmd.started;
                    end else begin
                        res_valid_next = 1'b1;
                        unique case (cmd.kind)
                            CMD_READ: res_next.read_empty = 1'b1;
                            CMD_KILL: begin
                                edit_idx_next        = commit_idx_reg;
                                res_next.erase_count = erase_wide[9:0];
                            end
                            CMD_ERASE: begin
                                if (edit_idx_reg != commit_idx_reg) begin
                                    edit_idx_next        = idx_dec(edit_idx_reg);
                                    res_next.erase_count = 10'd1;
                                end
                            end
                            CMD_STORE: begin
                                if (idx_dist(edit_idx_reg, read_idx_reg) < DEPTH) begin
                                    wr_en              = 1'b1;
                                    edit_idx_next      = edit_inc;
                                    res_next.echo_valid = 1'b1;
                                    res_next.echo_byte  = cmd.key;
                                    if (cmd.key == KEY_LF || cmd.key == KEY_CTRL_D ||
                                        idx_dist(edit_inc, read_idx_reg) == DEPTH) begin
                                        commit_idx_next         = edit_inc;
                                        res_next.line_committed = 1'b1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_READ: begin
                state_next     = ST_IDLE;
                res_valid_next = 1'b1;
                res_next       = '0;
                if (rd_data_reg == KEY_CTRL_D) begin
                    res_next.read_eof = 1'b1;
                    if (!started_reg) begin
                        read_idx_next = idx_inc(read_idx_reg);
                    end
                end else begin
                    read_idx_next          = idx_inc(read_idx_reg);
                    res_next.read_valid    = 1'b1;
                    res_next.read_byte     = rd_data_reg;
                    res_next.read_line_end = (rd_data_reg == KEY_LF);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            read_idx_reg   <= '0;
            commit_idx_reg <= '0;
            edit_idx_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            read_idx_reg   <= read_idx_next;
            commit_idx_reg <= commit_idx_next;
            edit_idx_reg   <= edit_idx_next;
            res_valid_reg  <= res_valid_next;
        end
        started_reg <= started_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[slot(edit_idx_reg)] <= cmd.key;
        end
        rd_data_reg <= mem[slot(read_idx_reg)];
    end

endmodule

// ===== hdl/console_line_editor_core.sv =====
// Top level of the console line editor: front classifier, queue, back end.
`timescale 1ns / 1ps
//
//  Channel   Dir  Ports         Word content
//  --------  ---  ------------  --------------------------------------------------
//  s_axis    in   tvalid/tready tuser = operation; tdata = key_byte, read_started
//  m_axis    out  tvalid/tready tlast = read_line_end; tdata = other result fields
//
//  A key word is handled by the back end in ST_IDLE; a read word that finds a
//  committed byte also passes ST_READ (registered read of the line buffer), and
//  the back end takes no new word until it is back in ST_IDLE.
//  From input accept to result valid a word passes the front command register, a
//  queue slot and the result register, plus any wait in the queue or on tready.
//  Reset (aresetn low, synchronous) clears the three indices, the queue and all
//  valid flags; the line buffer is not cleared and needs no clearing pass.
//  Front and back stall independently through a two-entry queue; the result
//  register holds its word while m_axis_tready is low.
//
module console_line_editor_core #(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] key_byte, [8] read_started, [15:9] zero
    input  logic        s_axis_tuser,   // [0] operation: 0 key, 1 read
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] echo_valid, [8:1] echo_byte,
                                        // [18:9] erase_count, [19] line_committed,
                                        // [20] read_valid, [28:21] read_byte,
                                        // [29] read_eof, [30] read_empty, [31] zero
    output logic        m_axis_tlast    // read_line_end
);
    import cle_pkg::*;

    logic f_valid, f_ready;
    cmd_t f_cmd;
    logic q_valid, q_ready;
    cmd_t q_cmd;
    res_t res;

    // Front: classify key words and read requests
    cle_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_operation (s_axis_tuser),
        .s_key       (s_axis_tdata[7:0]),
        .s_started   (s_axis_tdata[8]),
        .cmd_valid   (f_valid),
        .cmd_ready   (f_ready),
        .cmd         (f_cmd)
    );

    // Decoupling queue
    cle_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // Back: buffer, indices and result register
    cle_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pack the result word; read_line_end leaves on tlast
    assign m_axis_tdata = {1'b0, res.read_empty, res.read_eof, res.read_byte,
                           res.read_valid, res.line_committed, res.erase_count,
                           res.echo_byte, res.echo_valid};
    assign m_axis_tlast = res.read_line_end;

endmodule

// ===== bench/cle_tb_pkg.sv =====
// Operation codes shared by the console line editor testbench files.
`timescale 1ns / 1ps
package cle_tb_pkg;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

// ===== bench/console_line_editor_checker.sv =====
// Console line editor checker: line-buffer predictor and result word compare.
`timescale 1ns / 1ps
module console_line_editor_checker #(
    parameter int DEPTH = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending_count
);
    import cle_pkg::*;
    import cle_tb_pkg::*;

    localparam int PTR_W        = $clog2(2 * DEPTH);
    localparam int REPORT_LIMIT = 10;

    // mirror of the line buffer and its read / commit / edit pointers
    logic [7:0]       mirror_store [DEPTH];
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] cm_ptr;
    logic [PTR_W-1:0] ed_ptr;
    res_t             awaited_words [$];
    int               mismatches = 0;

    function automatic res_t edit_line_step(input logic op, input logic [7:0] key,
                                            input logic started);
        res_t             word;
        logic [7:0]       ch;
        logic [PTR_W-1:0] fill;
        word = '0;
        fill = ed_ptr - rd_ptr;
        if (op == OP_KEY) begin
            ch = key;
            if (ch == KEY_CTRL_U) begin
                word.erase_count = 10'(ed_ptr - cm_ptr);
                ed_ptr = cm_ptr;
            end else if (ch == KEY_BS || ch == KEY_DEL) begin
                if (ed_ptr != cm_ptr) begin
                    ed_ptr = ed_ptr - 1'b1;
                    word.erase_count = 10'd1;
                end
            end else if (ch == KEY_NUL || ch == KEY_TAB || ch == KEY_CTRL_P) begin
                word = '0;
            end else if (fill < DEPTH) begin
                if (ch == KEY_CR)
                    ch = KEY_LF;
                mirror_store[ed_ptr[PTR_W-2:0]] = ch;
                ed_ptr = ed_ptr + 1'b1;
                fill = ed_ptr - rd_ptr;
                word.echo_valid = 1'b1;
                word.echo_byte = ch;
                // LF, Ctrl-D or a full buffer makes the line readable
                if (ch == KEY_LF || ch == KEY_CTRL_D || fill == DEPTH) begin
                    cm_ptr = ed_ptr;
                    word.line_committed = 1'b1;
                end
            end
        end else begin
            if (rd_ptr == cm_ptr) begin
                word.read_empty = 1'b1;
            end else begin
                ch = mirror_store[rd_ptr[PTR_W-2:0]];
                if (ch == KEY_CTRL_D) begin
                    // Ctrl-D stays put when the read call already got bytes
                    if (!started)
                        rd_ptr = rd_ptr + 1'b1;
                    word.read_eof = 1'b1;
                end else begin
                    rd_ptr = rd_ptr + 1'b1;
                    word.read_valid = 1'b1;
                    word.read_byte = ch;
                    word.read_line_end = (ch == KEY_LF);
                end
            end
        end
        return word;
    endfunction

    task automatic note_mismatch(input string field, input int want_v, input int got_v);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch in %s: expected %0h, got %0h", field, want_v, got_v);
    endtask

    task automatic check_word();
        res_t seen;
        res_t want;
        seen.echo_valid     = m_axis_tdata[0];
        seen.echo_byte      = m_axis_tdata[8:1];
        seen.erase_count    = m_axis_tdata[18:9];
        seen.line_committed = m_axis_tdata[19];
        seen.read_valid     = m_axis_tdata[20];
        seen.read_byte      = m_axis_tdata[28:21];
        seen.read_eof       = m_axis_tdata[29];
        seen.read_empty     = m_axis_tdata[30];
        seen.read_line_end  = m_axis_tlast;
        if (awaited_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("word with nothing expected: tdata %h tlast %b",
                         m_axis_tdata, m_axis_tlast);
        end else begin
            want = awaited_words.pop_front();
            if (seen.echo_valid != want.echo_valid)
                note_mismatch("echo_valid", want.echo_valid, seen.echo_valid);
            if (seen.echo_byte != want.echo_byte)
                note_mismatch("echo_byte", want.echo_byte, seen.echo_byte);
            if (seen.erase_count != want.erase_count)
                note_mismatch("erase_count", want.erase_count, seen.erase_count);
            if (seen.line_committed != want.line_committed)
                note_mismatch("line_committed", want.line_committed, seen.line_committed);
            if (seen.read_valid != want.read_valid)
                note_mismatch("read_valid", want.read_valid, seen.read_valid);
            if (seen.read_byte != want.read_byte)
                note_mismatch("read_byte", want.read_byte, seen.read_byte);
            if (seen.read_line_end != want.read_line_end)
                note_mismatch("read_line_end", want.read_line_end, seen.read_line_end);
            if (seen.read_eof != want.read_eof)
                note_mismatch("read_eof", want.read_eof, seen.read_eof);
            if (seen.read_empty != want.read_empty)
                note_mismatch("read_empty", want.read_empty, seen.read_empty);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr = '0;
            cm_ptr = '0;
            ed_ptr = '0;
            awaited_words.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if (s_axis_tvalid && s_axis_tready)
                awaited_words.push_back(edit_line_step(s_axis_tuser, s_axis_tdata[7:0],
                                                       s_axis_tdata[8]));
        end
        pending_count <= awaited_words.size();
        fail_count    <= mismatches;
    end

endmodule

// ===== bench/console_line_editor_core_tb.sv =====
// Testbench top for the console line editor: stimulus, idling, watchdog, verdict.
`timescale 1ns / 1ps
module console_line_editor_core_tb;
    import cle_pkg::*;
    import cle_tb_pkg::*;

    localparam int DEPTH          = 512;
    localparam int MAX_IDLE       = 14;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MIXED_FIRST    = 150;
    localparam int MIXED_LAST     = 80;
    localparam int FLOOD_KEYS     = DEPTH + 8;
    localparam int FLOOD_READS    = DEPTH + 18;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [7:0] key_byte, [8] read_started, [15:9] zero
    logic        s_axis_tuser;   // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [0] echo_valid, [8:1] echo_byte, [18:9] erase_count,
                                 // [19] line_committed, [20] read_valid,
                                 // [28:21] read_byte, [29] read_eof, [30] read_empty
    logic        m_axis_tlast;   // read_line_end

    int   fail_words;
    int   pending_words;
    int   idle_cycles;
    logic calm;                  // high: neither side inserts gaps or stalls

    console_line_editor_core #(
        .BUFFER_DEPTH(DEPTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    console_line_editor_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_words),
        .pending_count (pending_words)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Offer one word. Entered right after a falling edge; returns at the falling
    // edge after the word was taken. tvalid is only lowered when a gap is drawn,
    // so back-to-back words never see a low-high pair in one time step.
    task automatic send_word(input logic op, input logic [7:0] key, input logic started);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, started, key};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge aclk);
    endtask

    // read_started means nothing to a key word, so it is left random there
    task automatic key_word(input logic [7:0] key);
        send_word(OP_KEY, key, 1'($urandom_range(0, 1)));
    endtask

    task automatic read_word(input logic started);
        send_word(OP_READ, 8'($urandom_range(0, 255)), started);
    endtask

    // Keystrokes shaped like real typing: mostly text, regular line ends, some
    // editing, now and then a control code or an arbitrary byte.
    function automatic logic [7:0] typed_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 8'($urandom_range(8'h20, 8'h7e));
        else if (pick < 68)
            return KEY_LF;
        else if (pick < 74)
            return KEY_CR;
        else if (pick < 78)
            return KEY_CTRL_D;
        else if (pick < 84)
            return KEY_BS;
        else if (pick < 88)
            return KEY_DEL;
        else if (pick < 91)
            return KEY_CTRL_U;
        else if (pick < 92)
            return KEY_NUL;
        else if (pick < 93)
            return KEY_TAB;
        else if (pick < 94)
            return KEY_CTRL_P;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mixed traffic: about a third reads so the buffer drains behind the typist.
    task automatic mixed_traffic(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 35)
                read_word(1'($urandom_range(0, 1)));
            else
                key_word(typed_key());
        end
    endtask

    // Result side: a fresh stall drawn after every accepted word.
    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge aclk);
        end
    end

    // Watchdog: a stretch without a single accepted word that runs past the watchdog limit ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int n;
        logic [7:0] flood_byte;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = OP_KEY;
        s_axis_tdata  = '0;
        calm          = 1'b0;
        idle_cycles   = 0;
        aresetn       = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed: empty buffer cases ---
        read_word(1'b0);            // nothing committed
        key_word(KEY_BS);           // nothing to erase
        key_word(KEY_DEL);
        key_word(KEY_CTRL_U);       // kill on empty line, count zero
        key_word(KEY_NUL);          // dropped codes
        key_word(KEY_TAB);
        key_word(KEY_CTRL_P);
        // --- directed: editing an uncommitted line ---
        key_word(8'h61);
        key_word(8'hff);
        key_word(8'h80);
        key_word(8'h01);
        key_word(KEY_BS);           // rubs out 0x01
        key_word(KEY_DEL);          // rubs out 0x80
        key_word(KEY_CTRL_U);       // rubs out the rest, count two
        // --- directed: commit on CR, then read the line back ---
        key_word(8'h78);
        key_word(KEY_CR);           // stored and echoed as LF, commits
        read_word(1'b0);
        read_word(1'b1);            // LF ends the read
        // --- directed: end of file handling ---
        key_word(KEY_CTRL_D);       // commits on its own
        read_word(1'b1);            // EOF, Ctrl-D stays for the next call
        read_word(1'b0);            // EOF, Ctrl-D consumed
        read_word(1'b0);            // empty again

        // --- random typing and reading ---
        mixed_traffic(MIXED_FIRST);

        // --- fill the buffer to the brim without reading ---
        // Plain bytes only; the full buffer commits by itself and the
        // overflow bytes are dropped.
        calm = 1'b0;
        for (n = 0; n < FLOOD_KEYS; n++) begin
            flood_byte = 8'($urandom_range(8'h20, 8'hff));
            if (flood_byte == KEY_DEL)
                flood_byte = 8'h7e;
            key_word(flood_byte);
        end
        key_word(KEY_BS);           // nothing uncommitted left to erase
        key_word(KEY_CTRL_U);
        for (n = 0; n < FLOOD_READS; n++) begin
            if (n % 128 == 0)
                calm = ($urandom_range(0, 2) == 0);
            read_word(1'($urandom_range(0, 1)));
        end

        // --- more random traffic, now past the pointer wrap ---
        mixed_traffic(MIXED_LAST);

        s_axis_tvalid <= 1'b0;
        while (pending_words != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_words == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
